>>> rtl/tts_pkg.sv
// ----------------------------------------------------------------------------
// Texture tile splitter package
// Shared payload types and register indexes for the tile splitter.
// ----------------------------------------------------------------------------
package tts_pkg;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_MIN_TILE_WIDTH     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_TILE_WIDTH     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_TILE_HEIGHT    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_TILE_HEIGHT    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_POW2_REQUIRED      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_NON_SQUARE_ALLOWED = 3'd5;

  localparam logic        AXIS_COLUMN = 1'b0;
  localparam logic        AXIS_ROW    = 1'b1;
  localparam logic [16:0] POW2_START  = 17'h10000;

  typedef struct packed {
    logic [15:0] image_width;
    logic [15:0] image_height;
  } tts_in_t;

  typedef struct packed {
    logic        axis;
    logic [4:0]  tile_index;
    logic [15:0] tile_size;
    logic [5:0]  tile_count;
    logic        overflow;
    logic        last;
  } tts_out_t;

endpackage

>>> rtl/tts_stream_if.sv
// ----------------------------------------------------------------------------
// Stream channel
// Valid/ready channel carrying one payload item per handshake.
// ----------------------------------------------------------------------------
interface tts_stream_if #(
  parameter type T = logic [31:0]
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/texture_tile_splitter.sv
// ----------------------------------------------------------------------------
// Texture tile splitter
// Splits an image width and height into texture tiles under the configured
// tile-size limits and emits one entry per tile column, then per tile row.
// ----------------------------------------------------------------------------
// Usage: write the six limit registers through cfg_we/cfg_index/cfg_data while
// the block is idle, then offer an image size on in_if (tts_in_t). Each item
// produces a run of tts_out_t entries on out_if: all column widths, then all
// row heights, with last set on the final row entry.
// Flow: the block takes one item at a time; in_if.ready is high only while
// the sequencer is idle. Per axis a set-up step and a 16-step restoring
// divider run first, then a prepare and a count step, followed by the
// emission of the entries. Non-square power-of-two mode adds a greedy tail
// walk per axis, done once to count and once to emit; square power-of-two
// mode adds a walk that picks the common size before the first axis. The
// divider serves both axes; the power-of-two register and the subtractor
// serve the tail walk and the emission, and the register also the square
// pick. Reset restores the default limits and empties the output
// register. A stalled receiver holds the current entry in the output
// register and the sequencer waits; the next item is taken as soon as the
// last entry of a run is registered, even while it still waits.
// ----------------------------------------------------------------------------
module texture_tile_splitter
  import tts_pkg::*;
#(
  parameter int MAX_TILES     = 32,
  parameter int MIN_POW2_TILE = 4
) (
  input  logic                  clk,
  input  logic                  rst_n,
  tts_stream_if.sink            in_if,
  tts_stream_if.source          out_if,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam logic [16:0] MAX_T17 = 17'(MAX_TILES);
  localparam logic [5:0]  MAX_T6  = 6'(MAX_TILES);
  localparam logic [15:0] MIN_P16 = 16'(MIN_POW2_TILE);

  typedef enum logic [2:0] {
    S_IDLE, S_SQPICK, S_SETUP, S_DIV, S_PREP, S_TAIL, S_COUNT, S_EMIT
  } state_t;

  function automatic logic [15:0] nz16(input logic [15:0] v);
    return (v == 16'd0) ? 16'd1 : v;
  endfunction

  function automatic logic [15:0] max16(input logic [15:0] a, input logic [15:0] b);
    return (a > b) ? a : b;
  endfunction

  function automatic logic [15:0] min16(input logic [15:0] a, input logic [15:0] b);
    return (a < b) ? a : b;
  endfunction

  // One greedy power-of-two pick; p is the smallest power of two not below rem.
  function automatic logic [15:0] pick(input logic [15:0] rem, input logic [16:0] p,
                                       input logic [15:0] mn, input logic [15:0] mx);
    logic [15:0] s;
    logic [16:0] sum;
    logic        halve;
    s     = ({1'b0, mx} < p) ? mx : p[15:0];
    sum   = {1'b0, rem} + {1'b0, mn};
    halve = (s < mn) || (sum < {1'b0, s});
    if (halve) begin
      s = s >> 1;
      if (s < mn) begin
        s = mn;
      end
    end
    if (rem > mx) begin
      s = mx;
    end
    if (rem < mn) begin
      s = mn;
    end
    return s;
  endfunction

  state_t      state_r, state_nxt;
  logic [15:0] min_w_r, max_w_r, min_h_r, max_h_r;
  logic        pow2_r, nsq_r;
  logic [15:0] len0_r, len0_nxt, len1_r, len1_nxt;
  logic        axis_r, axis_nxt;
  logic [15:0] mn_r, mn_nxt, mx_r, mx_nxt, ts_r, ts_nxt;
  logic [15:0] rem_r, rem_nxt;
  logic [16:0] p_r, p_nxt;
  logic [15:0] dvd_r, dvd_nxt, acc_r, acc_nxt;
  logic [3:0]  dcnt_r, dcnt_nxt;
  logic [5:0]  tcnt_r, tcnt_nxt;
  logic [16:0] tot_r, tot_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        ov_r, ov_nxt;
  logic [5:0]  idx_r, idx_nxt;
  logic        out_valid_r, out_valid_nxt;
  tts_out_t    out_r, out_nxt;

  logic        pow2ns, sqp2;
  logic [15:0] in_w, in_h;
  logic [15:0] mn0, mx0, mn1, mx1, a_len, a_mn, a_mx, sq_t, sq_lo, sq_hi, mnp;
  logic [16:0] div_t;
  logic        div_ge;
  logic        shrink;
  logic [15:0] pick_s;
  logic        emit_ok, in_body, is_end;
  logic [5:0]  idx_inc;
  logic [16:0] extra, tot_sum;
  logic [15:0] base_s;

  assign pow2ns = pow2_r & nsq_r;
  assign sqp2   = pow2_r & ~nsq_r;

  assign in_w = nz16(in_if.data.image_width);
  assign in_h = nz16(in_if.data.image_height);
  assign mn0  = nz16(min_w_r);
  assign mx0  = nz16(max_w_r);
  assign mn1  = nz16(min_h_r);
  assign mx1  = nz16(max_h_r);

  assign sq_t  = max16(min16(mx0, mx1), max16(mn0, mn1));
  assign sq_lo = max16(max16(mn0, mn1), MIN_P16);
  assign sq_hi = max16(min16(mx0, mx1), sq_lo);

  assign a_len = axis_r ? len1_r : len0_r;
  assign a_mn  = axis_r ? mn1 : mn0;
  assign a_mx  = axis_r ? mx1 : mx0;
  assign mnp   = max16(a_mn, MIN_P16);

  assign div_t  = {acc_r, dvd_r[15]};
  assign div_ge = div_t >= {1'b0, mx_r};

  assign shrink  = (p_r > 17'd1) && ((p_r >> 1) >= {1'b0, rem_r});
  assign pick_s  = pick(rem_r, p_r, mn_r, mx_r);
  assign emit_ok = ~out_valid_r | out_if.ready;
  assign in_body = ~pow2ns | ({10'd0, idx_r} < dvd_r);
  assign idx_inc = idx_r + 6'd1;
  assign is_end  = idx_inc == cnt_r;

  assign extra   = pow2ns ? {11'd0, tcnt_r} : {16'd0, (acc_r != 16'd0)};
  assign tot_sum = {1'b0, dvd_r} + extra;
  assign base_s  = (({11'd0, idx_inc} == tot_r) && (acc_r != 16'd0)) ? acc_r : mx_r;

  assign in_if.ready  = (state_r == S_IDLE);
  assign out_if.valid = out_valid_r;
  assign out_if.data  = out_r;

  always_comb begin
    state_nxt     = state_r;
    len0_nxt      = len0_r;
    len1_nxt      = len1_r;
    axis_nxt      = axis_r;
    mn_nxt        = mn_r;
    mx_nxt        = mx_r;
    ts_nxt        = ts_r;
    rem_nxt       = rem_r;
    p_nxt         = p_r;
    dvd_nxt       = dvd_r;
    acc_nxt       = acc_r;
    dcnt_nxt      = dcnt_r;
    tcnt_nxt      = tcnt_r;
    tot_nxt       = tot_r;
    cnt_nxt       = cnt_r;
    ov_nxt        = ov_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r & ~out_if.ready;
    out_nxt       = out_r;

    case (state_r)
      S_IDLE: begin
        if (in_if.valid) begin
          len0_nxt = in_w;
          len1_nxt = in_h;
          axis_nxt = AXIS_COLUMN;
          // Square power-of-two mode picks one size from the longer side.
          rem_nxt  = max16(in_w, in_h);
          p_nxt    = POW2_START;
          mn_nxt   = sq_lo;
          mx_nxt   = sq_hi;
          state_nxt = sqp2 ? S_SQPICK : S_SETUP;
        end
      end
      S_SQPICK: begin
        if (shrink) begin
          p_nxt = p_r >> 1;
        end else begin
          ts_nxt    = pick_s;
          state_nxt = S_SETUP;
        end
      end
      S_SETUP: begin
        if (sqp2) begin
          mn_nxt = ts_r;
          mx_nxt = ts_r;
        end else if (pow2_r) begin
          mn_nxt = mnp;
          mx_nxt = max16(a_mx, mnp);
        end else begin
          mn_nxt = a_mn;
          mx_nxt = nsq_r ? a_mx : sq_t;
        end
        dvd_nxt   = pow2ns ? (a_len - 16'd1) : a_len;
        acc_nxt   = 16'd0;
        dcnt_nxt  = 4'd0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        acc_nxt  = div_ge ? 16'(div_t - {1'b0, mx_r}) : div_t[15:0];
        dvd_nxt  = {dvd_r[14:0], div_ge};
        dcnt_nxt = dcnt_r + 4'd1;
        if (dcnt_r == 4'd15) begin
          state_nxt = S_PREP;
        end
      end
      S_PREP: begin
        // Power-of-two tail starts after the run of full-size tiles.
        rem_nxt   = acc_r + 16'd1;
        p_nxt     = POW2_START;
        tcnt_nxt  = 6'd0;
        state_nxt = pow2ns ? S_TAIL : S_COUNT;
      end
      S_TAIL: begin
        if (shrink) begin
          p_nxt = p_r >> 1;
        end else begin
          tcnt_nxt = tcnt_r + 6'd1;
          if (pick_s >= rem_r) begin
            state_nxt = S_COUNT;
          end else begin
            rem_nxt = rem_r - pick_s;
          end
        end
      end
      S_COUNT: begin
        tot_nxt   = tot_sum;
        ov_nxt    = tot_sum > MAX_T17;
        cnt_nxt   = (tot_sum > MAX_T17) ? MAX_T6 : tot_sum[5:0];
        idx_nxt   = 6'd0;
        rem_nxt   = acc_r + 16'd1;
        p_nxt     = POW2_START;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (!in_body && shrink) begin
          p_nxt = p_r >> 1;
        end else if (emit_ok) begin
          out_valid_nxt      = 1'b1;
          out_nxt.axis       = axis_r;
          out_nxt.tile_index = idx_r[4:0];
          out_nxt.tile_count = cnt_r;
          out_nxt.overflow   = ov_r;
          out_nxt.last       = axis_r & is_end;
          if (pow2ns) begin
            out_nxt.tile_size = in_body ? mx_r : pick_s;
          end else if (sqp2) begin
            out_nxt.tile_size = mx_r;
          end else begin
            out_nxt.tile_size = max16(base_s, mn_r);
          end
          if (!in_body) begin
            rem_nxt = (pick_s < rem_r) ? (rem_r - pick_s) : 16'd0;
          end
          idx_nxt = idx_inc;
          if (is_end) begin
            if (axis_r == AXIS_ROW) begin
              state_nxt = S_IDLE;
            end else begin
              axis_nxt  = AXIS_ROW;
              state_nxt = S_SETUP;
            end
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      min_w_r     <= 16'd1;
      max_w_r     <= 16'd256;
      min_h_r     <= 16'd1;
      max_h_r     <= 16'd256;
      pow2_r      <= 1'b0;
      nsq_r       <= 1'b1;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          REG_MIN_TILE_WIDTH:     min_w_r <= cfg_data;
          REG_MAX_TILE_WIDTH:     max_w_r <= cfg_data;
          REG_MIN_TILE_HEIGHT:    min_h_r <= cfg_data;
          REG_MAX_TILE_HEIGHT:    max_h_r <= cfg_data;
          REG_POW2_REQUIRED:      pow2_r  <= cfg_data[0];
          REG_NON_SQUARE_ALLOWED: nsq_r   <= cfg_data[0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    len0_r <= len0_nxt;
    len1_r <= len1_nxt;
    axis_r <= axis_nxt;
    mn_r   <= mn_nxt;
    mx_r   <= mx_nxt;
    ts_r   <= ts_nxt;
    rem_r  <= rem_nxt;
    p_r    <= p_nxt;
    dvd_r  <= dvd_nxt;
    acc_r  <= acc_nxt;
    dcnt_r <= dcnt_nxt;
    tcnt_r <= tcnt_nxt;
    tot_r  <= tot_nxt;
    cnt_r  <= cnt_nxt;
    ov_r   <= ov_nxt;
    idx_r  <= idx_nxt;
    out_r  <= out_nxt;
  end

  a_index_in_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ({1'b0, out_r.tile_index} < out_r.tile_count))
    else $error("tile index not below tile count");

  a_last_on_row: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.last) |-> (out_r.axis == AXIS_ROW))
    else $error("last set on a column entry");

  a_overflow_sat: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.overflow) |-> (out_r.tile_count == MAX_T6))
    else $error("overflow without saturated count");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_if.valid && in_if.ready) |=> !in_if.ready)
    else $error("item taken while a run is in progress");

endmodule
